FILE: hdl/pn3_pkg.sv
// Shared constants and types for the 3D gradient noise sampler.
package pn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int DW         = 36;  // corner dot and blend values
  localparam int MA_W       = 48;  // multiplier operand a, signed
  localparam int MB_W       = 18;  // multiplier operand b, signed
  localparam int MP_W       = 66;  // multiplier product, signed
  localparam int OUT_W      = 18;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [DW-1:0]    dval_t;
  typedef logic signed [MA_W-1:0]  mul_a_t;
  typedef logic signed [MB_W-1:0]  mul_b_t;
  typedef logic signed [MP_W-1:0]  mul_p_t;

endpackage

FILE: hdl/pn3_mul.sv
// Two-pass signed multiplier: low half product, then high half and sum.
module pn3_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pn3_pkg::mul_a_t a,
  input  pn3_pkg::mul_b_t b,
  output logic            done,
  output pn3_pkg::mul_p_t p
);
  import pn3_pkg::*;

  localparam int HALF = MA_W / 2;

  logic signed [HALF+MB_W:0]      lo_r;
  logic signed [HALF-1:0]         hi_r;
  mul_b_t                         b_r;
  logic signed [HALF+MB_W-1:0]    hi_p;
  mul_p_t                         p_r;
  logic                           ph1_r;
  logic                           done_r;

  assign hi_p = hi_r * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph1_r  <= start;
      done_r <= ph1_r;
    end
    if (start) begin
      lo_r <= $signed({1'b0, a[HALF-1:0]}) * b;
      hi_r <= a[MA_W-1:HALF];
      b_r  <= b;
    end
    if (ph1_r) begin
      p_r <= MP_W'(lo_r) + (MP_W'(hi_p) <<< HALF);
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: hdl/perlin_noise_3d_sampler.sv
// Top level: 3D gradient noise sampler with table memories and a sequencer.
//
// Input channel (in_*): one transfer is either a load (in_action = 0) that
// writes permutation entry and gradient triple at in_entry_index, or a
// sample (in_action = 1) carrying Q16.16 coordinates. A load gives no
// result. A sample gives one out_noise_value (Q3.15, saturated) on the
// out_* channel.
// A sample runs chained permutation reads through the single read port of
// the permutation memory, then for each of 8 corners one gradient read and
// three products, 12 products for the fade weights and 7 for the blend,
// all on one shared two-pass multiplier, and a final step to truncate and
// saturate. One sample is in flight at a time; in_stall is high while one
// is worked on.
// A finished result sits in the output register; the next transfer is
// taken while it waits. If out_stall holds it, the following sample stalls
// only in its final state, S_FIN, until the register frees.
// Reset: the permutation table reads as identity until entries are loaded
// (per-entry valid bits); gradients are undefined until loaded and all 256
// must be loaded before sampling.
module perlin_noise_3d_sampler (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [7:0]               in_entry_index,
  input  logic [7:0]               in_perm_value,
  input  logic signed [15:0]       in_grad_x,
  input  logic signed [15:0]       in_grad_y,
  input  logic signed [15:0]       in_grad_z,
  input  logic signed [31:0]       in_coord_x,
  input  logic signed [31:0]       in_coord_y,
  input  logic signed [31:0]       in_coord_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [pn3_pkg::OUT_W-1:0] out_noise_value
);
  import pn3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_GRD, S_DOT, S_FADE, S_LERP, S_FIN
  } state_t;

  state_t       state_r;
  logic [3:0]   cnt_r;
  logic [2:0]   m_r;
  logic [1:0]   ax_r;
  logic         mwait_r;

  idx_t         ix_r, iy_r, iz_r;
  logic [15:0]  tx_r, ty_r, tz_r;
  idx_t         a_r [2];
  idx_t         b_r [4];
  idx_t         h_r [8];
  dval_t        d_r [8];
  dval_t        acc_r;
  logic [47:0]  fr_r;
  logic [16:0]  w_r [3];

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_noise_r;

  // table memories
  logic [7:0]   perm_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] pval_r;
  logic [7:0]   pq_r;
  logic         pvq_r;
  idx_t         praq_r;
  logic [47:0]  grad_mem [TABLE_SIZE];
  logic [47:0]  gq_r;

  logic         in_xfer, load_we;
  idx_t         pra, perm_rd, iy1;
  logic [3:0]   n_rd, n_b, n_h;
  logic [2:0]   mh;

  logic         mstart, mdone;
  mul_a_t       ma;
  mul_b_t       mb;
  mul_p_t       mp;

  logic signed [16:0] fsel;
  logic signed [15:0] gsel;
  logic [15:0]  tsel;
  logic [47:0]  qv;
  dval_t        dlo, dhi;
  logic [2:0]   lidx;
  logic [1:0]   laxis;
  logic signed [DW:0] ldiff;
  logic signed [19:0] vsh;
  logic signed [OUT_W-1:0] sat_v;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign load_we   = in_xfer && !in_action;
  assign out_valid = out_valid_r;
  assign out_noise_value = out_noise_r;

  // permutation read address for the chained hash
  assign iy1  = iy_r + idx_t'(1);
  assign mh   = 3'(cnt_r - 4'd6);
  assign n_rd = cnt_r - 4'd1;
  assign n_b  = cnt_r - 4'd3;
  assign n_h  = cnt_r - 4'd7;

  always_comb begin
    pra = '0;
    case (cnt_r) inside
      4'd0:          pra = iz_r;
      4'd1:          pra = iz_r + idx_t'(1);
      [4'd2:4'd5]:   pra = (cnt_r[0] ? iy1 : iy_r) + a_r[cnt_r[2]];
      [4'd6:4'd13]:  pra = (mh[0] ? ix_r + idx_t'(1) : ix_r) + b_r[mh[2:1]];
      default:       pra = '0;
    endcase
  end

  assign perm_rd = pvq_r ? idx_t'(pq_r) : praq_r;

  always_ff @(posedge clk) begin
    if (load_we) begin
      perm_mem[in_entry_index[IDX_W-1:0]] <= in_perm_value;
      grad_mem[in_entry_index[IDX_W-1:0]] <= {in_grad_x, in_grad_y, in_grad_z};
    end
    pq_r   <= perm_mem[pra];
    praq_r <= pra;
    if (state_r == S_GRD) begin
      gq_r <= grad_mem[h_r[m_r]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pval_r <= '0;
      pvq_r  <= 1'b0;
    end else begin
      if (load_we) begin
        pval_r[in_entry_index[IDX_W-1:0]] <= 1'b1;
      end
      pvq_r <= pval_r[pra];
    end
  end

  // multiplier operands
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin fsel = $signed({m_r[0], tx_r}); gsel = $signed(gq_r[47:32]); end
      2'd1:    begin fsel = $signed({m_r[1], ty_r}); gsel = $signed(gq_r[31:16]); end
      default: begin fsel = $signed({m_r[2], tz_r}); gsel = $signed(gq_r[15:0]);  end
    endcase
  end

  always_comb begin
    case (cnt_r)
      4'd0:    begin lidx = 3'd0; dlo = d_r[0]; dhi = d_r[1]; laxis = 2'd0; end
      4'd1:    begin lidx = 3'd2; dlo = d_r[2]; dhi = d_r[3]; laxis = 2'd0; end
      4'd2:    begin lidx = 3'd4; dlo = d_r[4]; dhi = d_r[5]; laxis = 2'd0; end
      4'd3:    begin lidx = 3'd6; dlo = d_r[6]; dhi = d_r[7]; laxis = 2'd0; end
      4'd4:    begin lidx = 3'd0; dlo = d_r[0]; dhi = d_r[2]; laxis = 2'd1; end
      4'd5:    begin lidx = 3'd4; dlo = d_r[4]; dhi = d_r[6]; laxis = 2'd1; end
      default: begin lidx = 3'd0; dlo = d_r[0]; dhi = d_r[4]; laxis = 2'd2; end
    endcase
  end

  assign ldiff = (DW+1)'(dhi) - (DW+1)'(dlo);

  always_comb begin
    case (ax_r)
      2'd0:    tsel = tx_r;
      2'd1:    tsel = ty_r;
      default: tsel = tz_r;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_DOT: begin
        ma = MA_W'(fsel);
        mb = MB_W'(gsel);
      end
      S_FADE: begin
        ma = (cnt_r == 4'd0) ? mul_a_t'({32'd0, tsel}) : $signed(fr_r);
        mb = $signed({2'b00, tsel});
      end
      S_LERP: begin
        ma = MA_W'(ldiff);
        mb = $signed({1'b0, w_r[laxis]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mstart = !mwait_r &&
                  (state_r == S_DOT || state_r == S_FADE || state_r == S_LERP);

  pn3_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  // fade polynomial head: 6t^2 - 15*2^16*t + 10*2^32
  assign qv = (48'(mp[31:0]) << 2) + (48'(mp[31:0]) << 1) + (48'd10 << 32)
            - (48'(tsel) << 20) + (48'(tsel) << 16);

  assign vsh = d_r[0][DW-1:16];
  always_comb begin
    if (vsh[19:17] == 3'b000 || vsh[19:17] == 3'b111) begin
      sat_v = vsh[OUT_W-1:0];
    end else if (vsh[19]) begin
      sat_v = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_v = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      m_r         <= '0;
      ax_r        <= '0;
      mwait_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (mstart) begin
        mwait_r <= 1'b1;
      end else if (mdone) begin
        mwait_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_action) begin
            ix_r    <= in_coord_x[16+IDX_W-1:16];
            iy_r    <= in_coord_y[16+IDX_W-1:16];
            iz_r    <= in_coord_z[16+IDX_W-1:16];
            tx_r    <= in_coord_x[15:0];
            ty_r    <= in_coord_y[15:0];
            tz_r    <= in_coord_z[15:0];
            cnt_r   <= '0;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          case (cnt_r) inside
            [4'd1:4'd2]:  a_r[n_rd[0]]   <= perm_rd;
            [4'd3:4'd6]:  b_r[n_b[1:0]]  <= perm_rd;
            [4'd7:4'd14]: h_r[n_h[2:0]]  <= perm_rd;
            default: ;
          endcase
          if (cnt_r == 4'd14) begin
            m_r     <= '0;
            state_r <= S_GRD;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_GRD: begin
          cnt_r   <= '0;
          state_r <= S_DOT;
        end
        S_DOT: begin
          if (mwait_r && mdone) begin
            if (cnt_r == 4'd2) begin
              d_r[m_r] <= acc_r + DW'(mp);
              if (m_r == 3'd7) begin
                cnt_r   <= '0;
                ax_r    <= '0;
                state_r <= S_FADE;
              end else begin
                m_r     <= m_r + 3'd1;
                state_r <= S_GRD;
              end
            end else begin
              acc_r <= ((cnt_r == 4'd0) ? dval_t'(0) : acc_r) + DW'(mp);
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        S_FADE: begin
          if (mwait_r && mdone) begin
            if (cnt_r == 4'd0) begin
              fr_r  <= qv;
              cnt_r <= cnt_r + 4'd1;
            end else if (cnt_r == 4'd3) begin
              w_r[ax_r] <= mp[48:32];
              cnt_r     <= '0;
              if (ax_r == 2'd2) begin
                state_r <= S_LERP;
              end else begin
                ax_r <= ax_r + 2'd1;
              end
            end else begin
              fr_r  <= mp[63:16];
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        S_LERP: begin
          if (mwait_r && mdone) begin
            d_r[lidx] <= dlo + DW'(mp >>> 16);
            if (cnt_r == 4'd6) begin
              state_r <= S_FIN;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_noise_r <= sat_v;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pn3_chk.sv
// Port-level checker for the noise sampler, bound to the top level.
module pn3_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [pn3_pkg::OUT_W-1:0] out_noise_value
);
  import pn3_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("held result changed");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action |=> in_stall)
    else $error("sample transfer did not make the block busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_action |=> !in_stall)
    else $error("load transfer left the block busy");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind perlin_noise_3d_sampler pn3_chk u_pn3_chk (.*);
